>>> sv/beam_pkg.sv
`timescale 1ns / 1ps
package beam_pkg;

	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int COORD_W     = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_LINE_LEFT   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LINE_RIGHT  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_LINE_TOP    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_LINE_BOTTOM = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_BED_NEEDED  = 3'd4;

	localparam logic [1:0] MOVE_IN  = 2'd1;
	localparam logic [1:0] MOVE_OUT = 2'd2;

	typedef enum logic [1:0] {
		MODE_STANDBY = 2'd0,
		MODE_MONITOR = 2'd1,
		MODE_SAFE    = 2'd2,
		MODE_ALERT   = 2'd3
	} mode_t;

	// classified track word, front to back
	typedef struct packed {
		logic reinit;
		logic moved_out;
		logic moved_in;
		logic in_line;
		logic in_bed;
		logic last;
	} entry_t;

	typedef struct packed {
		mode_t status;
		logic  alarm_fired;
		logic  human_in_bed;
		logic  clear_move_out;
		logic  clear_move_in;
	} result_t;

endpackage

>>> sv/beam_fifo.sv
`timescale 1ns / 1ps
module beam_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/beam_front.sv
`timescale 1ns / 1ps
module beam_front
	import beam_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_INDEX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    cmd,
	input  logic                    entry_valid,
	input  logic signed [COORD_W-1:0] pos_x,
	input  logic signed [COORD_W-1:0] pos_y,
	input  logic [1:0]              move_status,
	input  logic                    in_bed,
	input  logic                    last_entry,
	output entry_t                  word
);

	logic signed [COORD_W-1:0] left_q, right_q, top_q, bottom_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			right_q  <= '0;
			top_q    <= '0;
			bottom_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LINE_LEFT:   left_q   <= cfg_data;
				REG_LINE_RIGHT:  right_q  <= cfg_data;
				REG_LINE_TOP:    top_q    <= cfg_data;
				REG_LINE_BOTTOM: bottom_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// invalid slots still report moves; only the box test needs a person
	always_comb begin
		word.reinit    = cmd;
		word.moved_out = (move_status == MOVE_OUT);
		word.moved_in  = (move_status == MOVE_IN);
		word.in_line   = entry_valid && (pos_x < left_q) && (pos_x > right_q)
			&& (pos_y < top_q) && (pos_y > bottom_q);
		word.in_bed    = in_bed;
		word.last      = last_entry;
	end

endmodule

>>> sv/beam_back.sv
`timescale 1ns / 1ps
module beam_back
	import beam_pkg::*;
#(
	parameter int COUNT_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  entry_t                 word,
	input  logic                   word_empty,
	output logic                   word_pop,
	output result_t                res,
	output logic                   res_push,
	input  logic                   res_full
);

	localparam int CMP_W = (COUNT_BITS > CFG_DATA_W) ? COUNT_BITS : CFG_DATA_W;

	logic [CFG_DATA_W-1:0] needed_q;
	mode_t                 mode_q, mode_d;
	logic [COUNT_BITS-1:0] count_q, count_d;
	logic                  armed_q, armed_d;
	logic                  seen_out_q, seen_in_q, seen_line_q;
	logic                  mo, mi, inl, bed, done;
	logic                  alarm, clr_out, clr_in;

	assign word_pop = !word_empty && (word.reinit || !word.last || !res_full);
	assign res_push = word_pop && !word.reinit && word.last;

	assign mo  = seen_out_q || word.moved_out;
	assign mi  = seen_in_q || word.moved_in;
	assign inl = seen_line_q || word.in_line;
	assign bed = word.in_bed;

	// frame-end rules; done marks an early exit
	always_comb begin
		mode_d  = mode_q;
		count_d = count_q;
		armed_d = armed_q;
		alarm   = 1'b0;
		clr_out = 1'b0;
		clr_in  = 1'b0;
		done    = (mode_q == MODE_ALERT);
		if (!done) begin
			if (bed) begin
				if (mode_q == MODE_STANDBY) begin
					if (count_q != '1) begin
						count_d = count_q + 1'b1;
					end
					if (CMP_W'(count_d) < CMP_W'(needed_q)) begin
						done = 1'b1;
					end else begin
						mode_d  = MODE_MONITOR;
						armed_d = 1'b1;
					end
				end
			end else begin
				count_d = '0;
				mode_d  = MODE_STANDBY;
			end
		end
		if (!done && mo) begin
			if (mode_d != MODE_SAFE && armed_d) begin
				alarm  = 1'b1;
				mode_d = MODE_ALERT;
				done   = 1'b1;
			end else if (!bed) begin
				mode_d = MODE_STANDBY;
				done   = 1'b1;
			end else begin
				if (!inl) begin
					mode_d = MODE_MONITOR;
				end
				clr_out = 1'b1;
			end
		end
		if (!done && mi) begin
			if (mode_d == MODE_STANDBY && armed_d) begin
				armed_d = 1'b0;
				done    = 1'b1;
			end else if (!bed) begin
				mode_d = MODE_STANDBY;
				done   = 1'b1;
			end else begin
				mode_d = MODE_SAFE;
				clr_in = 1'b1;
			end
		end
		if (!done && bed && !inl) begin
			mode_d = MODE_MONITOR;
		end
	end

	always_comb begin
		res.status         = mode_d;
		res.alarm_fired    = alarm;
		res.human_in_bed   = bed;
		res.clear_move_out = clr_out;
		res.clear_move_in  = clr_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needed_q <= CFG_DATA_W'(1);
		end else if (cfg_we && cfg_index == REG_BED_NEEDED) begin
			needed_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_STANDBY;
			count_q     <= '0;
			armed_q     <= 1'b0;
			seen_out_q  <= 1'b0;
			seen_in_q   <= 1'b0;
			seen_line_q <= 1'b0;
		end else if (word_pop) begin
			if (word.reinit) begin
				mode_q      <= MODE_STANDBY;
				count_q     <= '0;
				armed_q     <= 1'b0;
				seen_out_q  <= 1'b0;
				seen_in_q   <= 1'b0;
				seen_line_q <= 1'b0;
			end else if (word.last) begin
				mode_q      <= mode_d;
				count_q     <= count_d;
				armed_q     <= armed_d;
				seen_out_q  <= 1'b0;
				seen_in_q   <= 1'b0;
				seen_line_q <= 1'b0;
			end else begin
				seen_out_q  <= mo;
				seen_in_q   <= mi;
				seen_line_q <= inl;
			end
		end
	end

`ifndef SYNTHESIS
	a_alarm_means_alert: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && res.alarm_fired |-> res.status == MODE_ALERT)
		else $error("alarm without alert status");

	a_alert_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_ALERT && !(word_pop && word.reinit) |=> mode_q == MODE_ALERT)
		else $error("alert left without re-initialise");

	a_clear_in_needs_bed: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && res.clear_move_in |-> res.human_in_bed)
		else $error("move-in clear without person in bed");

	a_no_result_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_full |-> !res_push)
		else $error("result pushed into full queue");
`endif

endmodule

>>> sv/bed_exit_alarm_monitor_top.sv
`timescale 1ns / 1ps
// Bed-exit alarm monitor. Push one tracked-person word per cycle; the word marked
// last_entry closes the frame and yields one result word (status, alarm pulse,
// in-bed echo, clear requests), and cmd=1 re-initialises without a result. A
// word is classified against the line box on entry and waits in a four-deep queue
// until the rule engine takes it, one per cycle except when a last word meets a full
// result queue; results wait in a two-deep queue. Sustained rate is one word per cycle,
// set by the combinational rule step; a result passes the word queue and then the result
// queue before the result ports. Write configuration only while both queues are empty.
module bed_exit_alarm_monitor_top
	import beam_pkg::*;
#(
	parameter int COUNT_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic                      push,
	output logic                      full,
	input  logic                      cmd,
	input  logic                      entry_valid,
	input  logic signed [COORD_W-1:0] pos_x,
	input  logic signed [COORD_W-1:0] pos_y,
	input  logic [1:0]                move_status,
	input  logic                      in_bed,
	input  logic                      last_entry,
	output logic                      empty,
	input  logic                      pop,
	output logic [1:0]                status,
	output logic                      alarm_fired,
	output logic                      human_in_bed,
	output logic                      clear_move_out,
	output logic                      clear_move_in
);

	localparam int WORD_DEPTH = 4;
	localparam int RES_DEPTH  = 2;

	entry_t  front_word, back_word;
	logic    word_empty, word_pop;
	result_t back_res, out_res;
	logic    res_push, res_full;

	beam_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.entry_valid (entry_valid),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.move_status (move_status),
		.in_bed      (in_bed),
		.last_entry  (last_entry),
		.word        (front_word)
	);

	beam_fifo #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (WORD_DEPTH)
	) u_word_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (front_word),
		.rd_en   (word_pop),
		.rd_data (back_word),
		.full    (full),
		.empty   (word_empty)
	);

	beam_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.word       (back_word),
		.word_empty (word_empty),
		.word_pop   (word_pop),
		.res        (back_res),
		.res_push   (res_push),
		.res_full   (res_full)
	);

	beam_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (RES_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (back_res),
		.rd_en   (pop),
		.rd_data (out_res),
		.full    (res_full),
		.empty   (empty)
	);

	assign status         = out_res.status;
	assign alarm_fired    = out_res.alarm_fired;
	assign human_in_bed   = out_res.human_in_bed;
	assign clear_move_out = out_res.clear_move_out;
	assign clear_move_in  = out_res.clear_move_in;

endmodule

>>> bench/tb_bed_exit_alarm_monitor_top.sv
`timescale 1ns / 1ps
module tb_bed_exit_alarm_monitor_top;
	import beam_pkg::*;

	// narrow counter so that saturation is reachable in a short run
	localparam int BED_COUNT_BITS = 8;

	localparam logic       CMD_TRACK  = 1'b0;
	localparam logic       CMD_REINIT = 1'b1;
	localparam logic [1:0] MOVE_NONE  = 2'd0;
	localparam logic [1:0] MOVE_ODD   = 2'd3;

	typedef struct {
		logic                      cmd;
		logic                      entry_valid;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic [1:0]                move_status;
		logic                      in_bed;
		logic                      last_entry;
	} track_word_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]     cfg_data = '0;
	logic                      push = 1'b0;
	logic                      cmd = 1'b0;
	logic                      entry_valid = 1'b0;
	logic signed [COORD_W-1:0] pos_x = '0;
	logic signed [COORD_W-1:0] pos_y = '0;
	logic [1:0]                move_status = '0;
	logic                      in_bed = 1'b0;
	logic                      last_entry = 1'b0;
	logic                      pop = 1'b0;
	logic                      full;
	logic                      empty;
	logic [1:0]                status;
	logic                      alarm_fired;
	logic                      human_in_bed;
	logic                      clear_move_out;
	logic                      clear_move_in;

	// configuration copy
	logic signed [COORD_W-1:0] box_left = '0;
	logic signed [COORD_W-1:0] box_right = '0;
	logic signed [COORD_W-1:0] box_top = '0;
	logic signed [COORD_W-1:0] box_bottom = '0;
	logic [CFG_DATA_W-1:0]     bed_needed = 16'd1;

	// monitor state copy
	mode_t                     room_mode = MODE_STANDBY;
	logic [BED_COUNT_BITS-1:0] bed_run = '0;
	logic                      armed = 1'b0;
	logic                      saw_exit = 1'b0;
	logic                      saw_return = 1'b0;
	logic                      saw_line = 1'b0;

	track_word_t track_q[$];
	result_t     frame_reports_q[$];
	track_word_t cur_word;
	int          errors = 0;
	int          tx_wait = 0;
	int          rx_wait = 0;
	bit          tx_steady = 1'b0;
	bit          rx_steady = 1'b0;

	bed_exit_alarm_monitor_top #(.COUNT_BITS(BED_COUNT_BITS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.cmd(cmd),
		.entry_valid(entry_valid),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.move_status(move_status),
		.in_bed(in_bed),
		.last_entry(last_entry),
		.empty(empty),
		.pop(pop),
		.status(status),
		.alarm_fired(alarm_fired),
		.human_in_bed(human_in_bed),
		.clear_move_out(clear_move_out),
		.clear_move_in(clear_move_in)
	);

	always #6 clk = ~clk;

	function automatic track_word_t mk(input logic c, input logic v, input logic [15:0] x,
			input logic [15:0] y, input logic [1:0] ms, input logic b, input logic l);
		track_word_t w;
		w.cmd = c;
		w.entry_valid = v;
		w.pos_x = x;
		w.pos_y = y;
		w.move_status = ms;
		w.in_bed = b;
		w.last_entry = l;
		return w;
	endfunction

	// frame-end rules; early returns leave later clear requests low
	function automatic void close_frame(input logic bed, output logic alarm,
			output logic clr_out, output logic clr_in);
		alarm = 1'b0;
		clr_out = 1'b0;
		clr_in = 1'b0;
		if (room_mode == MODE_ALERT)
			return;
		if (bed) begin
			if (room_mode == MODE_STANDBY) begin
				if (bed_run != '1)
					bed_run++;
				if (bed_run < bed_needed)
					return;
				room_mode = MODE_MONITOR;
				armed = 1'b1;
			end
		end else begin
			bed_run = '0;
			room_mode = MODE_STANDBY;
		end
		if (saw_exit) begin
			if (room_mode != MODE_SAFE && armed) begin
				alarm = 1'b1;
				room_mode = MODE_ALERT;
				return;
			end
			if (!bed) begin
				room_mode = MODE_STANDBY;
				return;
			end
			if (!saw_line)
				room_mode = MODE_MONITOR;
			clr_out = 1'b1;
		end
		if (saw_return) begin
			if (room_mode == MODE_STANDBY && armed) begin
				armed = 1'b0;
				return;
			end
			if (!bed) begin
				room_mode = MODE_STANDBY;
				return;
			end
			room_mode = MODE_SAFE;
			clr_in = 1'b1;
		end
		if (bed && !saw_line)
			room_mode = MODE_MONITOR;
	endfunction

	function automatic void absorb_track_word(input track_word_t w);
		logic    alarm;
		logic    clr_out;
		logic    clr_in;
		result_t r;
		if (w.cmd == CMD_REINIT) begin
			room_mode = MODE_STANDBY;
			bed_run = '0;
			armed = 1'b0;
			saw_exit = 1'b0;
			saw_return = 1'b0;
			saw_line = 1'b0;
			return;
		end
		if (w.move_status == MOVE_OUT)
			saw_exit = 1'b1;
		if (w.move_status == MOVE_IN)
			saw_return = 1'b1;
		if (w.entry_valid && w.pos_x < box_left && w.pos_x > box_right &&
				w.pos_y < box_top && w.pos_y > box_bottom)
			saw_line = 1'b1;
		if (!w.last_entry)
			return;
		close_frame(w.in_bed, alarm, clr_out, clr_in);
		saw_exit = 1'b0;
		saw_return = 1'b0;
		saw_line = 1'b0;
		r.status = room_mode;
		r.alarm_fired = alarm;
		r.human_in_bed = w.in_bed;
		r.clear_move_out = clr_out;
		r.clear_move_in = clr_in;
		frame_reports_q.push_back(r);
	endfunction

	// coordinate biased toward the open interval (lo, hi) and its edges
	function automatic logic [15:0] pick_coord(input int lo, input int hi);
		case ($urandom_range(0, 5))
			0, 1: begin
				if (hi - lo >= 2)
					return 16'(lo + 1 + int'($urandom_range(0, hi - lo - 2)));
				return 16'(lo + 1);
			end
			2: return 16'(lo);
			3: return 16'(hi);
			4: return 16'(hi - 1);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [1:0] pick_move();
		int r;
		r = $urandom_range(0, 19);
		if (r < 2)
			return MOVE_OUT;
		if (r < 4)
			return MOVE_IN;
		if (r == 4)
			return MOVE_ODD;
		return MOVE_NONE;
	endfunction

	function automatic track_word_t junk_reinit();
		return mk(CMD_REINIT, 1'($urandom), 16'($urandom), 16'($urandom), 2'($urandom),
			1'($urandom), 1'($urandom));
	endfunction

	task automatic queue_frames(input int n_words, input int bed_pct, input int cmd_pct);
		int  added;
		int  len;
		bit  bed;
		added = 0;
		while (added < n_words) begin
			if ($urandom_range(0, 99) < cmd_pct) begin
				track_q.push_back(junk_reinit());
				added++;
			end
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 9) : $urandom_range(1, 3);
			bed = $urandom_range(0, 99) < bed_pct;
			for (int k = 0; k < len; k++) begin
				// break the frame now and then
				if (k > 0 && $urandom_range(0, 199) < cmd_pct) begin
					track_q.push_back(junk_reinit());
					added++;
				end
				track_q.push_back(mk(CMD_TRACK, $urandom_range(0, 7) != 0,
					pick_coord(box_right, box_left), pick_coord(box_bottom, box_top),
					pick_move(), (k == len - 1) ? bed : 1'($urandom), k == len - 1));
				added++;
			end
		end
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_LINE_LEFT:   box_left = data;
			REG_LINE_RIGHT:  box_right = data;
			REG_LINE_TOP:    box_top = data;
			REG_LINE_BOTTOM: box_bottom = data;
			REG_BED_NEEDED:  bed_needed = data;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input int l, input int r, input int t, input int b,
			input int needed);
		write_reg(REG_LINE_LEFT, 16'(l));
		write_reg(REG_LINE_RIGHT, 16'(r));
		write_reg(REG_LINE_TOP, 16'(t));
		write_reg(REG_LINE_BOTTOM, 16'(b));
		write_reg(REG_BED_NEEDED, 16'(needed));
	endtask

	task automatic random_box(input int needed);
		int a;
		int b;
		int c;
		int d;
		a = int'($signed(16'($urandom)));
		b = int'($signed(16'($urandom)));
		c = int'($signed(16'($urandom)));
		d = int'($signed(16'($urandom)));
		if ($urandom_range(0, 3) == 0)
			b = a - int'($urandom_range(0, 3));
		set_config((a > b) ? a : b, (a > b) ? b : a, (c > d) ? c : d, (c > d) ? d : c, needed);
	endtask

	// sample at the falling edge, then let in-flight words drain
	task automatic wait_idle();
		do
			@(negedge clk);
		while (track_q.size() != 0 || push || frame_reports_q.size() != 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			errors++;
		end
	endtask

	// sender: present one word per handshake with a random gap before each
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				absorb_track_word(cur_word);
			if (!push || !full) begin
				if (tx_wait > 0) begin
					push <= 1'b0;
					tx_wait--;
				end else if (track_q.size() != 0) begin
					cur_word = track_q.pop_front();
					push <= 1'b1;
					cmd <= cur_word.cmd;
					entry_valid <= cur_word.entry_valid;
					pos_x <= cur_word.pos_x;
					pos_y <= cur_word.pos_y;
					move_status <= cur_word.move_status;
					in_bed <= cur_word.in_bed;
					last_entry <= cur_word.last_entry;
					tx_wait = tx_steady ? 0 : $urandom_range(0, 16);
					if ($urandom_range(0, 39) == 0)
						tx_steady = !tx_steady;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// receiver: compare each popped word with the oldest prediction
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (frame_reports_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual status %0d",
						$time, status);
					errors++;
				end else begin
					check_field("status", frame_reports_q[0].status, status);
					check_field("alarm_fired", frame_reports_q[0].alarm_fired, alarm_fired);
					check_field("human_in_bed", frame_reports_q[0].human_in_bed, human_in_bed);
					check_field("clear_move_out", frame_reports_q[0].clear_move_out,
						clear_move_out);
					check_field("clear_move_in", frame_reports_q[0].clear_move_in,
						clear_move_in);
					void'(frame_reports_q.pop_front());
				end
				rx_wait = rx_steady ? 0 : $urandom_range(0, 16);
				if ($urandom_range(0, 39) == 0)
					rx_steady = !rx_steady;
			end else if (rx_wait > 0) begin
				rx_wait--;
			end
			pop <= (rx_wait == 0);
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset configuration: the line box is empty
		track_q.push_back(mk(CMD_TRACK, 1'b1, 16'h0000, 16'h0000, MOVE_NONE, 1'b1, 1'b1));
		track_q.push_back(mk(CMD_TRACK, 1'b1, 16'h8000, 16'h7fff, MOVE_OUT, 1'b1, 1'b1));
		wait_idle();

		set_config(100, -100, 100, -100, 1);
		track_q.push_back(mk(CMD_REINIT, 1'b1, 16'h7fff, 16'h8000, MOVE_OUT, 1'b1, 1'b1));
		track_q.push_back(mk(CMD_TRACK, 1'b1, 16'h0000, 16'h0000, MOVE_NONE, 1'b1, 1'b1));
		track_q.push_back(mk(CMD_TRACK, 1'b1, 16'd100, 16'h0000, MOVE_NONE, 1'b0, 1'b0));
		track_q.push_back(mk(CMD_TRACK, 1'b1, -16'sd100, 16'h0000, MOVE_NONE, 1'b0, 1'b0));
		track_q.push_back(mk(CMD_TRACK, 1'b0, 16'h0000, 16'h0000, MOVE_IN, 1'b0, 1'b0));
		track_q.push_back(mk(CMD_TRACK, 1'b1, 16'd99, -16'sd99, MOVE_ODD, 1'b1, 1'b1));
		track_q.push_back(mk(CMD_TRACK, 1'b0, 16'h0000, 16'h0000, MOVE_OUT, 1'b1, 1'b1));
		track_q.push_back(mk(CMD_TRACK, 1'b1, 16'h7fff, 16'h7fff, MOVE_IN, 1'b0, 1'b1));
		track_q.push_back(mk(CMD_TRACK, 1'b1, 16'h8000, 16'h8000, MOVE_NONE, 1'b1, 1'b0));
		track_q.push_back(mk(CMD_REINIT, 1'b0, 16'hffff, 16'hffff, MOVE_ODD, 1'b0, 1'b0));
		track_q.push_back(mk(CMD_TRACK, 1'b1, 16'h0000, 16'd99, MOVE_OUT, 1'b0, 1'b1));
		track_q.push_back(mk(CMD_TRACK, 1'b1, 16'h0000, 16'h0000, MOVE_IN, 1'b0, 1'b1));
		track_q.push_back(mk(CMD_TRACK, 1'b1, 16'hffff, 16'h0001, MOVE_IN, 1'b1, 1'b1));
		track_q.push_back(mk(CMD_TRACK, 1'b1, 16'h0000, 16'h0000, MOVE_OUT, 1'b1, 1'b1));
		track_q.push_back(mk(CMD_TRACK, 1'b1, 16'd50, 16'd50, MOVE_OUT, 1'b0, 1'b0));
		track_q.push_back(mk(CMD_TRACK, 1'b1, -16'sd50, -16'sd50, MOVE_IN, 1'b1, 1'b1));
		track_q.push_back(mk(CMD_TRACK, 1'b1, 16'd500, 16'h0000, MOVE_OUT, 1'b0, 1'b1));
		track_q.push_back(mk(CMD_REINIT, 1'b0, 16'h0000, 16'h0000, MOVE_NONE, 1'b0, 1'b0));
		track_q.push_back(mk(CMD_TRACK, 1'b1, 16'h0000, 16'h0000, MOVE_IN, 1'b0, 1'b1));
		track_q.push_back(mk(CMD_TRACK, 1'b1, 16'h0000, 16'h0000, MOVE_NONE, 1'b1, 1'b1));
		track_q.push_back(mk(CMD_TRACK, 1'b1, 16'h0000, 16'h0000, MOVE_IN, 1'b0, 1'b1));

		for (int p = 0; p < 8; p++) begin
			wait_idle();
			case (p)
				0: random_box(2);
				1: set_config(32767, -32768, 32767, -32768, 1);
				2: set_config(int'($signed(16'($urandom))), int'($signed(16'($urandom))),
					int'($signed(16'($urandom))), int'($signed(16'($urandom))), 0);
				3: set_config(-32768, 32767, -32768, 32767, 3);
				4: set_config(0, 0, 0, 0, 300);
				5: random_box(200);
				6: random_box(65535);
				default: random_box($urandom_range(1, 5));
			endcase
			if (p == 4) begin
				// long in-bed standby run drives the frame count into saturation
				track_q.push_back(mk(CMD_REINIT, 1'b0, 16'h0000, 16'h0000, MOVE_NONE,
					1'b0, 1'b0));
				queue_frames(700, 100, 0);
			end else begin
				// a saturated count must arm at once under the lower threshold
				if (p == 5)
					track_q.push_back(mk(CMD_TRACK, 1'b1, 16'h0000, 16'h0000, MOVE_NONE,
						1'b1, 1'b1));
				queue_frames(200, 80, 8);
			end
		end

		wait_idle();
		if (errors == 0 && frame_reports_q.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
